@@ rtl/core/tcr_pkg.sv @@
// Shared types and character codes for the text command recognizer.
package tcr_pkg;

  localparam int WIN_DEPTH = 7;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [2:0] {
    CMD_OFF     = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_START   = 3'd2,
    CMD_SCALE_F = 3'd3,
    CMD_SCALE_C = 3'd4,
    CMD_PERIOD  = 3'd5
  } command_t;

  // Which command texts end the byte window right now.
  typedef struct packed {
    logic off;
    logic stop;
    logic start;
    logic scale_f;
    logic scale_c;
    logic period_kw;
  } match_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] period_now;
    logic        report_on;
    logic        fahrenheit;
    logic        redundant;
  } result_t;

endpackage

@@ rtl/core/tcr_if.sv @@
// Valid/ready channel interfaces for the command bytes and the results.
interface tcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface tcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] period_now;
  logic        report_on;
  logic        fahrenheit;
  logic        redundant;

  modport source (output valid, output command, output period_now, output report_on,
                  output fahrenheit, output redundant, input ready);
  modport sink (input valid, input command, input period_now, input report_on,
                input fahrenheit, input redundant, output ready);
endinterface

@@ rtl/core/tcr_window.sv @@
// Window of the last seven bytes and the command text matchers on it.
module tcr_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      byte_in,
  output tcr_pkg::match_t match
);
  import tcr_pkg::*;

  // Entry 0 is the newest byte.
  logic [7:0] recent [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN_DEPTH; k++) recent[k] <= 8'h00;
    end else if (push) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) recent[k] <= recent[k - 1];
      recent[0] <= byte_in;
    end
  end

  logic scale_head;
  assign scale_head = (recent[6] == CH_S) && (recent[5] == CH_C) && (recent[4] == CH_A) &&
                      (recent[3] == CH_L) && (recent[2] == CH_E) && (recent[1] == CH_EQ);

  assign match.off = (recent[2] == CH_O) && (recent[1] == CH_F) && (recent[0] == CH_F);
  assign match.stop = (recent[3] == CH_S) && (recent[2] == CH_T) && (recent[1] == CH_O) &&
                      (recent[0] == CH_P);
  assign match.start = (recent[4] == CH_S) && (recent[3] == CH_T) && (recent[2] == CH_A) &&
                       (recent[1] == CH_R) && (recent[0] == CH_T);
  assign match.scale_f = scale_head && (recent[0] == CH_F);
  assign match.scale_c = scale_head && (recent[0] == CH_C);
  assign match.period_kw = (recent[5] == CH_P) && (recent[4] == CH_E) && (recent[3] == CH_R) &&
                           (recent[2] == CH_I) && (recent[1] == CH_O) && (recent[0] == CH_D);

endmodule

@@ rtl/core/tcr_ctrl.sv @@
// Command decision, period digit accumulator and the reporting flags.
module tcr_ctrl #(
  parameter int PERIOD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       byte_in,
  input  tcr_pkg::match_t  match,
  output logic             live,
  output logic             res_valid,
  output tcr_pkg::result_t res
);
  import tcr_pkg::*;

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

  logic                   in_digits, in_digits_next;
  logic                   have_digit, have_digit_next;
  logic [PERIOD_BITS-1:0] acc, acc_next;
  logic [PERIOD_BITS-1:0] period, period_next;
  logic                   report_en, report_en_next;
  logic                   scale_f, scale_f_next;
  logic                   halted, halted_next;

  logic                   is_nl, is_digit, is_eq;
  logic [PERIOD_BITS+3:0] acc_times_ten;
  logic [PERIOD_BITS+3:0] acc_sum;
  logic                   found;
  command_t               cmd;
  logic                   redundant;
  logic [31:0]            period_wide;

  assign is_nl    = (byte_in == CH_NL);
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign is_eq    = (byte_in == CH_EQ);

  // acc * 10 + digit; any bit above the period width means saturation.
  assign acc_times_ten = ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0});
  assign acc_sum = acc_times_ten + {{PERIOD_BITS{1'b0}}, byte_in[3:0]};

  always_comb begin
    in_digits_next  = in_digits;
    have_digit_next = have_digit;
    acc_next        = acc;
    period_next     = period;
    report_en_next  = report_en;
    scale_f_next    = scale_f;
    halted_next     = halted;
    found           = 1'b0;
    cmd             = CMD_OFF;
    redundant       = 1'b0;
    if (is_nl) begin
      if (in_digits && have_digit) begin
        period_next = acc;
        cmd         = CMD_PERIOD;
        found       = 1'b1;
      end else if (match.off) begin
        halted_next = 1'b1;
        cmd         = CMD_OFF;
        found       = 1'b1;
      end else if (match.stop) begin
        redundant      = ~report_en;
        report_en_next = 1'b0;
        cmd            = CMD_STOP;
        found          = 1'b1;
      end else if (match.start) begin
        redundant      = report_en;
        report_en_next = 1'b1;
        cmd            = CMD_START;
        found          = 1'b1;
      end else if (match.scale_f) begin
        scale_f_next = 1'b1;
        cmd          = CMD_SCALE_F;
        found        = 1'b1;
      end else if (match.scale_c) begin
        scale_f_next = 1'b0;
        cmd          = CMD_SCALE_C;
        found        = 1'b1;
      end
      in_digits_next  = 1'b0;
      have_digit_next = 1'b0;
    end else if (is_digit) begin
      if (in_digits) begin
        if (acc_sum[PERIOD_BITS+3:PERIOD_BITS] != 4'd0) begin
          acc_next = PERIOD_MAX;
        end else begin
          acc_next = acc_sum[PERIOD_BITS-1:0];
        end
        have_digit_next = 1'b1;
      end
    end else if (is_eq && match.period_kw) begin
      in_digits_next  = 1'b1;
      have_digit_next = 1'b0;
      acc_next        = '0;
    end else begin
      in_digits_next  = 1'b0;
      have_digit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_digits  <= 1'b0;
      have_digit <= 1'b0;
      acc        <= '0;
      period     <= PERIOD_BITS'(1);
      report_en  <= 1'b1;
      scale_f    <= 1'b0;
      halted     <= 1'b0;
    end else if (fire && !halted) begin
      in_digits  <= in_digits_next;
      have_digit <= have_digit_next;
      acc        <= acc_next;
      period     <= period_next;
      report_en  <= report_en_next;
      scale_f    <= scale_f_next;
      halted     <= halted_next;
    end
  end

  assign live        = ~halted;
  assign res_valid   = fire && !halted && found;
  assign period_wide = 32'(period_next);

  assign res.command    = cmd;
  assign res.period_now = period_wide[15:0];
  assign res.report_on  = report_en_next;
  assign res.fahrenheit = scale_f_next;
  assign res.redundant  = redundant;

endmodule

@@ rtl/core/text_command_recognizer_unit.sv @@
// Top level of the text command recognizer.
// Takes one ASCII byte per beat and reports each newline-terminated command (OFF, STOP, START,
// SCALE=F, SCALE=C, PERIOD=<digits>) found at the end of the stream as one result beat that
// carries the flags and the period as they stand after the command. A new byte is accepted in
// every cycle while nothing holds the stream back. A byte waits in the input register until
// it can advance; the recognition logic between the two registers decides it, and its result,
// if any, is loaded into the result register as the byte advances. The result register is
// the only thing that can hold the stream back, and only while a result waits there unread.
// After OFF every byte is accepted and dropped until reset.
module text_command_recognizer_unit #(
  parameter int PERIOD_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  tcr_in_if.sink      cmd_in,
  tcr_out_if.source   res_out
);
  import tcr_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       live;
  logic       res_valid;
  match_t     match;
  result_t    res;
  result_t    out_res;
  logic       out_valid;

  assign advance      = s1_valid && (!out_valid || res_out.ready);
  assign cmd_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_in.ready) begin
      s1_valid <= cmd_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.valid && cmd_in.ready) begin
      s1_byte <= cmd_in.byte_in;
    end
  end

  tcr_window u_window (
    .clk     (clk),
    .rst     (rst),
    .push    (advance && live),
    .byte_in (s1_byte),
    .match   (match)
  );

  tcr_ctrl #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .byte_in   (s1_byte),
    .match     (match),
    .live      (live),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign res_out.valid      = out_valid;
  assign res_out.command    = out_res.command;
  assign res_out.period_now = out_res.period_now;
  assign res_out.report_on  = out_res.report_on;
  assign res_out.fahrenheit = out_res.fahrenheit;
  assign res_out.redundant  = out_res.redundant;

endmodule

@@ rtl/core/tcr_checker.sv @@
// Port-level assertions for the text command recognizer and their binding.
module tcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  command,
  input logic [15:0] period_now,
  input logic        report_on,
  input logic        fahrenheit,
  input logic        redundant
);
  import tcr_pkg::*;

  logic seen_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_off <= 1'b0;
    end else if (out_valid && out_ready && (command == CMD_OFF)) begin
      seen_off <= 1'b1;
    end
  end

  // A result beat that is held back keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(period_now) &&
      $stable(report_on) && $stable(fahrenheit) && $stable(redundant))
    else $error("result beat changed while stalled");

  // Once OFF has been delivered the block stays silent until reset.
  assert property (@(posedge clk) disable iff (rst) seen_off |-> !out_valid)
    else $error("result after OFF");

  // Only STOP and START can be redundant.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && redundant |-> (command == CMD_STOP) || (command == CMD_START))
    else $error("redundant mark on a command other than STOP or START");

  // Flags shown must agree with the command that set them.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((command != CMD_STOP) || !report_on) &&
      ((command != CMD_START) || report_on) &&
      ((command != CMD_SCALE_F) || fahrenheit) &&
      ((command != CMD_SCALE_C) || !fahrenheit))
    else $error("flags disagree with command");

endmodule

bind text_command_recognizer_unit tcr_checker u_tcr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res_out.valid),
  .out_ready  (res_out.ready),
  .command    (res_out.command),
  .period_now (res_out.period_now),
  .report_on  (res_out.report_on),
  .fahrenheit (res_out.fahrenheit),
  .redundant  (res_out.redundant)
);
